@@ src/oom_pkg.sv @@
// ----------------------------------------------------------------------------
// oom_pkg
// Shared types and codes for the output override mixer: command codes,
// controller states and the control and status groups between the modules.
// ----------------------------------------------------------------------------
package oom_pkg;

   typedef enum logic [1:0] {
      OP_SET      = 2'd0,
      OP_OVERRIDE = 2'd1,
      OP_PROFILE  = 2'd2,
      OP_UPDATE   = 2'd3
   } op_type;

   typedef enum logic [1:0] {
      ST_IDLE,
      ST_WALK,
      ST_DRAIN,
      ST_EMIT
   } state_type;

   // profile flag bit positions
   localparam int FLAG_ACTIVE = 0;
   localparam int FLAG_FON    = 1;
   localparam int FLAG_FOFF   = 2;

   typedef struct packed {
      logic accept;
      logic start_walk;
      logic rd_en;
      logic emit;
   } oom_cmd_type;

   typedef struct packed {
      logic last_rd;
   } oom_status_type;

endpackage

@@ src/output_override_mixer.sv @@
// ----------------------------------------------------------------------------
// output_override_mixer
// Mixes requested output bits with a profile table and one-shot overrides.
//
//   channel   handshake        payload
//   command   start / busy     req_op, req_out_index, req_bit_value, req_profile_*
//   result    rsp_valid        rsp_drive_word, rsp_requested_word, rsp_forced_*
//
// set, override and profile write transfers complete on acceptance, busy stays low
// an update walks the profile table in steps: the transfer, one read of the profile
// memory per entry, a drain state to fold in the last entry and an emit state
// the result is shown for exactly one cycle; the receiver cannot stall
// synchronous reset clears requested bits, overrides and all profile flags
// ----------------------------------------------------------------------------
module output_override_mixer
   import oom_pkg::*;
#(
   parameter int PROFILES    = 16,
   parameter int OUTPUT_BITS = 32
)
(
   input  logic        clock,
   input  logic        reset,
   input  logic        start,
   output logic        busy,
   input  logic [1:0]  req_op,
   input  logic [4:0]  req_out_index,
   input  logic        req_bit_value,
   input  logic [3:0]  req_profile_index,
   input  logic [31:0] req_profile_mask,
   input  logic        req_profile_active,
   input  logic        req_profile_force_on,
   input  logic        req_profile_force_off,
   output logic        rsp_valid,
   output logic [31:0] rsp_drive_word,
   output logic [31:0] rsp_requested_word,
   output logic [31:0] rsp_forced_on_word,
   output logic [31:0] rsp_forced_off_word
);

   oom_cmd_type    cmd;
   oom_status_type status;

   oom_ctrl u_ctrl (
      .clock  (clock),
      .reset  (reset),
      .start  (start),
      .req_op (req_op),
      .status (status),
      .busy   (busy),
      .cmd    (cmd)
   );

   oom_datapath #(
      .PROFILES    (PROFILES),
      .OUTPUT_BITS (OUTPUT_BITS)
   ) u_datapath (
      .clock                 (clock),
      .reset                 (reset),
      .cmd                   (cmd),
      .status                (status),
      .req_op                (req_op),
      .req_out_index         (req_out_index),
      .req_bit_value         (req_bit_value),
      .req_profile_index     (req_profile_index),
      .req_profile_mask      (req_profile_mask),
      .req_profile_active    (req_profile_active),
      .req_profile_force_on  (req_profile_force_on),
      .req_profile_force_off (req_profile_force_off),
      .rsp_drive_word        (rsp_drive_word),
      .rsp_requested_word    (rsp_requested_word),
      .rsp_forced_on_word    (rsp_forced_on_word),
      .rsp_forced_off_word   (rsp_forced_off_word)
   );

   assign rsp_valid = cmd.emit;

endmodule

@@ src/oom_ctrl.sv @@
// ----------------------------------------------------------------------------
// oom_ctrl
// Controller: accepts commands and sequences the profile walk of an update.
// ----------------------------------------------------------------------------
module oom_ctrl
   import oom_pkg::*;
(
   input  logic           clock,
   input  logic           reset,
   input  logic           start,
   input  logic [1:0]     req_op,
   input  oom_status_type status,
   output logic           busy,
   output oom_cmd_type    cmd
);

   state_type state_ff, state_in;
   logic      accept;

   assign busy   = (state_ff != ST_IDLE);
   assign accept = start && !busy;

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= ST_IDLE;
      end else begin
         state_ff <= state_in;
      end
   end

   always_comb begin
      state_in = state_ff;
      unique case (state_ff)
         ST_IDLE: begin
            if (accept && (op_type'(req_op) == OP_UPDATE)) begin
               state_in = ST_WALK;
            end
         end
         ST_WALK: begin
            if (status.last_rd) begin
               state_in = ST_DRAIN;
            end
         end
         ST_DRAIN: begin
            state_in = ST_EMIT;
         end
         ST_EMIT: begin
            state_in = ST_IDLE;
         end
         default: begin
            state_in = ST_IDLE;
         end
      endcase
   end

   always_comb begin
      cmd            = '0;
      cmd.accept     = accept;
      unique case (state_ff)
         ST_IDLE: begin
            cmd.start_walk = accept && (op_type'(req_op) == OP_UPDATE);
         end
         ST_WALK: begin
            cmd.rd_en = 1'b1;
         end
         ST_DRAIN: begin
         end
         ST_EMIT: begin
            cmd.emit = 1'b1;
         end
         default: begin
         end
      endcase
   end

endmodule

@@ src/oom_datapath.sv @@
// ----------------------------------------------------------------------------
// oom_datapath
// Datapath: requested and override words, profile flags and mask memory,
// walk counter and accumulation of the update result.
// ----------------------------------------------------------------------------
module oom_datapath
   import oom_pkg::*;
#(
   parameter int PROFILES    = 16,
   parameter int OUTPUT_BITS = 32
)
(
   input  logic           clock,
   input  logic           reset,
   input  oom_cmd_type    cmd,
   output oom_status_type status,
   input  logic [1:0]     req_op,
   input  logic [4:0]     req_out_index,
   input  logic           req_bit_value,
   input  logic [3:0]     req_profile_index,
   input  logic [31:0]    req_profile_mask,
   input  logic           req_profile_active,
   input  logic           req_profile_force_on,
   input  logic           req_profile_force_off,
   output logic [31:0]    rsp_drive_word,
   output logic [31:0]    rsp_requested_word,
   output logic [31:0]    rsp_forced_on_word,
   output logic [31:0]    rsp_forced_off_word
);

   localparam int PW = (PROFILES > 1) ? $clog2(PROFILES) : 1;

   logic [OUTPUT_BITS-1:0] requested_ff, requested_in;
   logic [OUTPUT_BITS-1:0] pend_on_ff, pend_on_in;
   logic [OUTPUT_BITS-1:0] pend_off_ff, pend_off_in;
   logic [OUTPUT_BITS-1:0] acc_ff, acc_in;
   logic [2:0]             flags_ff [PROFILES];
   logic [2:0]             flags_in [PROFILES];
   logic [OUTPUT_BITS-1:0] mask_mem [PROFILES];
   logic [OUTPUT_BITS-1:0] mask_rd_ff;
   logic [2:0]             flags_rd_ff;
   logic                   rd_valid_ff;
   logic [PW-1:0]          cnt_ff, cnt_in;

   op_type                 op;
   logic                   out_ok;
   logic                   prof_ok;
   logic                   prof_wr;
   logic [PW-1:0]          prof_addr;
   logic [OUTPUT_BITS-1:0] out_bit;
   logic [OUTPUT_BITS-1:0] drive;

   assign op        = op_type'(req_op);
   assign out_ok    = (7'(req_out_index) < 7'(OUTPUT_BITS));
   assign prof_ok   = (7'(req_profile_index) < 7'(PROFILES));
   assign prof_wr   = cmd.accept && (op == OP_PROFILE) && prof_ok;
   assign prof_addr = PW'(req_profile_index);
   assign out_bit   = OUTPUT_BITS'(1) << req_out_index;

   assign status.last_rd = (cnt_ff == PW'(PROFILES - 1));

   // mask memory, no reset: an entry only counts once its flags are written
   always_ff @(posedge clock) begin
      if (prof_wr) begin
         mask_mem[prof_addr] <= OUTPUT_BITS'(req_profile_mask);
      end
      if (cmd.rd_en) begin
         mask_rd_ff <= mask_mem[cnt_ff];
      end
   end

   always_comb begin
      requested_in = requested_ff;
      pend_on_in   = pend_on_ff;
      pend_off_in  = pend_off_ff;
      acc_in       = acc_ff;
      cnt_in       = cnt_ff;
      for (int p = 0; p < PROFILES; p++) begin
         flags_in[p] = flags_ff[p];
         if (cmd.emit) begin
            flags_in[p][FLAG_FON]  = 1'b0;
            flags_in[p][FLAG_FOFF] = 1'b0;
         end
      end
      if (prof_wr) begin
         flags_in[prof_addr] = {req_profile_force_off, req_profile_force_on,
                                req_profile_active};
      end
      if (cmd.accept && out_ok) begin
         if (op == OP_SET) begin
            if (req_bit_value) begin
               requested_in = requested_ff | out_bit;
            end else begin
               requested_in = requested_ff & ~out_bit;
            end
         end else if (op == OP_OVERRIDE) begin
            if (req_bit_value) begin
               pend_on_in = pend_on_ff | out_bit;
            end else begin
               pend_off_in = pend_off_ff | out_bit;
            end
         end
      end
      if (cmd.start_walk) begin
         acc_in = requested_ff;
         cnt_in = '0;
      end
      if (cmd.rd_en) begin
         cnt_in = cnt_ff + PW'(1);
      end
      if (rd_valid_ff) begin
         if (flags_rd_ff[FLAG_ACTIVE]) begin
            acc_in = acc_ff | mask_rd_ff;
         end
         if (flags_rd_ff[FLAG_FON]) begin
            pend_on_in = pend_on_ff | mask_rd_ff;
         end
         if (flags_rd_ff[FLAG_FOFF]) begin
            pend_off_in = pend_off_ff | mask_rd_ff;
         end
      end
      if (cmd.emit) begin
         pend_on_in  = '0;
         pend_off_in = '0;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         requested_ff <= '0;
         pend_on_ff   <= '0;
         pend_off_ff  <= '0;
         rd_valid_ff  <= 1'b0;
         cnt_ff       <= '0;
         for (int p = 0; p < PROFILES; p++) begin
            flags_ff[p] <= '0;
         end
      end else begin
         requested_ff <= requested_in;
         pend_on_ff   <= pend_on_in;
         pend_off_ff  <= pend_off_in;
         rd_valid_ff  <= cmd.rd_en;
         cnt_ff       <= cnt_in;
         for (int p = 0; p < PROFILES; p++) begin
            flags_ff[p] <= flags_in[p];
         end
      end
   end

   always_ff @(posedge clock) begin
      acc_ff <= acc_in;
      if (cmd.rd_en) begin
         flags_rd_ff <= flags_ff[cnt_ff];
      end
   end

   assign drive = (acc_ff | pend_on_ff) & ~pend_off_ff;

   assign rsp_drive_word      = 32'(drive);
   assign rsp_requested_word  = 32'(acc_ff);
   assign rsp_forced_on_word  = 32'(pend_on_ff);
   assign rsp_forced_off_word = 32'(pend_off_ff);

endmodule

@@ src/oom_checker.sv @@
// ----------------------------------------------------------------------------
// oom_checker
// Port-level checks for the output override mixer, bound to the top level.
// ----------------------------------------------------------------------------
module oom_checker
   import oom_pkg::*;
(
   input logic        clock,
   input logic        reset,
   input logic        start,
   input logic        busy,
   input logic [1:0]  req_op,
   input logic        rsp_valid,
   input logic [31:0] rsp_drive_word,
   input logic [31:0] rsp_requested_word,
   input logic [31:0] rsp_forced_on_word,
   input logic [31:0] rsp_forced_off_word
);

   // an update transfer makes the block busy
   a_update_busy: assert property (@(posedge clock) disable iff (reset)
      (start && !busy && (req_op == OP_UPDATE)) |=> busy)
      else $error("update not started");

   // other transfers leave the block free
   a_short_free: assert property (@(posedge clock) disable iff (reset)
      (start && !busy && (req_op != OP_UPDATE)) |=> !busy)
      else $error("short command made block busy");

   // result strobe lasts one cycle and ends the update
   a_strobe_once: assert property (@(posedge clock) disable iff (reset)
      rsp_valid |=> (!rsp_valid && !busy))
      else $error("result strobe held");

   a_strobe_busy: assert property (@(posedge clock) disable iff (reset)
      rsp_valid |-> busy)
      else $error("result outside update");

   // drive word follows from the other result words
   a_drive_mix: assert property (@(posedge clock) disable iff (reset)
      rsp_valid |-> (rsp_drive_word ==
         ((rsp_requested_word | rsp_forced_on_word) & ~rsp_forced_off_word)))
      else $error("drive word mismatch");

endmodule

bind output_override_mixer oom_checker u_oom_checker (
   .clock               (clock),
   .reset               (reset),
   .start               (start),
   .busy                (busy),
   .req_op              (req_op),
   .rsp_valid           (rsp_valid),
   .rsp_drive_word      (rsp_drive_word),
   .rsp_requested_word  (rsp_requested_word),
   .rsp_forced_on_word  (rsp_forced_on_word),
   .rsp_forced_off_word (rsp_forced_off_word)
);
